@@ hdl/dcf_pkg.sv @@
// Shared constants, slot codes and the CRC-32 byte fold for the chunk framer.
`default_nettype none

package dcf_pkg;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

  // Configuration register indexes.
  localparam logic [1:0] CFG_START = 2'd0;
  localparam logic [1:0] CFG_END   = 2'd1;
  localparam logic [1:0] CFG_TYPE  = 2'd2;

  // Output slot codes within the bytes caused by one request.
  typedef logic [3:0] slot_t;
  localparam slot_t SLOT_START   = 4'd0;
  localparam slot_t SLOT_TYPE    = 4'd1;
  localparam slot_t SLOT_LEN_LO  = 4'd2;
  localparam slot_t SLOT_LEN_HI  = 4'd3;
  localparam slot_t SLOT_PAYLOAD = 4'd4;
  localparam slot_t SLOT_CRC0    = 4'd5;
  localparam slot_t SLOT_CRC1    = 4'd6;
  localparam slot_t SLOT_CRC2    = 4'd7;
  localparam slot_t SLOT_CRC3    = 4'd8;
  localparam slot_t SLOT_END     = 4'd9;

  // CRC-32, MSB first: fold one byte into the running value.
  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {data, 24'h0};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/data_chunk_framer_crc32.sv @@
// Chunk framer: wraps payload bytes in start/type/length header and CRC-32/end trailer.
//
// Every request carries one payload byte. The first request of a chunk also
// carries the chunk length (0 is taken as 1, values above MAX_CHUNK are
// clamped) and causes the start byte, the type byte and the 16-bit length,
// low byte first, to go out ahead of the payload byte. The request that closes
// the chunk causes the four bytes of the CRC-32 (polynomial 0x04C11DB7, MSB
// first, initial value all ones, no final XOR), low byte first, and then the
// end byte to follow it. packet_end_o marks the end byte and run_last_o marks
// the last byte caused by a request. Rate: the output port moves one byte per
// cycle while out_stall_i is low. A request yields one byte for a middle byte,
// five for a chunk's first, six for its last and ten for a one-byte chunk. The
// CRC fold and the length bookkeeping are done in the cycle a request is
// accepted; the result is held in a bundle register that the output slot
// counter walks, and the next request is taken in the same cycle as the last
// byte of the current bundle leaves, so a stream of middle payload bytes runs
// at one request per cycle with no bubble while out_stall_i stays low.
// Configuration registers are written through the plain write port (index 0
// start byte, 1 end byte, 2 type byte); writes to other indexes are ignored.
`default_nettype none

module data_chunk_framer_crc32 import dcf_pkg::*; #(
  parameter int unsigned MAX_CHUNK = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  payload_byte_i,
  input  wire logic [10:0] chunk_length_i,
  // Output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             packet_end_o,
  output logic             run_last_o,
  // Configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i
);

  // Largest length that can actually reach the counter: the input field has
  // 11 bits, and the clamp limits it further.
  localparam int unsigned LenMax = (MAX_CHUNK < 2047) ? MAX_CHUNK : 2047;
  localparam int unsigned RemW   = $clog2(LenMax + 1);

  // Configuration registers.
  logic [7:0] start_byte_q, end_byte_q, type_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= 8'd170;
      end_byte_q   <= 8'd187;
      type_byte_q  <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START: start_byte_q <= cfg_data_i;
        CFG_END:   end_byte_q   <= cfg_data_i;
        CFG_TYPE:  type_byte_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Chunk state.
  logic [RemW-1:0] rem_q, rem_d;
  logic [31:0]     crc_q, crc_d;

  // Bundle register: everything needed to emit the bytes of one request.
  logic            bnd_valid_q;
  logic            bnd_trl_q;
  logic [15:0]     bnd_len_q;
  logic [7:0]      bnd_byte_q;
  logic [31:0]     bnd_crc_q;
  slot_t           slot_q;

  logic            in_acc, out_take;
  slot_t           slot_last;
  logic            at_last;

  assign slot_last   = bnd_trl_q ? SLOT_END : SLOT_PAYLOAD;
  assign at_last     = (slot_q == slot_last);
  assign out_valid_o = bnd_valid_q;
  assign out_take    = bnd_valid_q && !out_stall_i;
  // A new request may enter when the bundle is empty or its last byte leaves now.
  assign in_stall_o  = bnd_valid_q && !(out_take && at_last);
  assign in_acc      = in_valid_i && !in_stall_o;

  // Per-request work: length adjust, CRC fold, remaining count.
  logic            hdr, trl;
  logic [16:0]     len_ext;
  logic [RemW-1:0] len_adj;
  logic [RemW-1:0] rem_base;
  logic [31:0]     crc_base, crc_new;

  always_comb begin
    hdr     = (rem_q == '0);
    len_ext = 17'(chunk_length_i);
    if (len_ext == 17'd0) begin
      len_adj = RemW'(1);
    end else if (len_ext > 17'(MAX_CHUNK)) begin
      len_adj = RemW'(LenMax);
    end else begin
      len_adj = RemW'(chunk_length_i);
    end
    rem_base = hdr ? len_adj : rem_q;
    rem_d    = rem_base - RemW'(1);
    trl      = (rem_d == '0);
    crc_base = hdr ? CRC_INIT : crc_q;
    crc_new  = crc_fold(crc_base, payload_byte_i);
    crc_d    = trl ? CRC_INIT : crc_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      crc_q       <= CRC_INIT;
      bnd_valid_q <= 1'b0;
      slot_q      <= SLOT_PAYLOAD;
    end else begin
      if (in_acc) begin
        rem_q       <= rem_d;
        crc_q       <= crc_d;
        bnd_valid_q <= 1'b1;
        slot_q      <= hdr ? SLOT_START : SLOT_PAYLOAD;
      end else if (out_take) begin
        if (at_last) begin
          bnd_valid_q <= 1'b0;
        end else begin
          slot_q <= slot_q + slot_t'(1);
        end
      end
    end
  end

  // Payload part of the bundle needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      bnd_trl_q  <= trl;
      bnd_len_q  <= 16'(len_adj);
      bnd_byte_q <= payload_byte_i;
      bnd_crc_q  <= crc_new;
    end
  end

  // Output byte selection.
  always_comb begin
    case (slot_q)
      SLOT_START:   out_byte_o = start_byte_q;
      SLOT_TYPE:    out_byte_o = type_byte_q;
      SLOT_LEN_LO:  out_byte_o = bnd_len_q[7:0];
      SLOT_LEN_HI:  out_byte_o = bnd_len_q[15:8];
      SLOT_PAYLOAD: out_byte_o = bnd_byte_q;
      SLOT_CRC0:    out_byte_o = bnd_crc_q[7:0];
      SLOT_CRC1:    out_byte_o = bnd_crc_q[15:8];
      SLOT_CRC2:    out_byte_o = bnd_crc_q[23:16];
      SLOT_CRC3:    out_byte_o = bnd_crc_q[31:24];
      SLOT_END:     out_byte_o = end_byte_q;
      default:      out_byte_o = bnd_byte_q;
    endcase
  end

  assign packet_end_o = (slot_q == SLOT_END);
  assign run_last_o   = at_last;

  // The end byte always closes the bytes of its request.
  a_end_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_end_o |-> run_last_o)
    else $error("end byte not marked as last of its request");

  // A request that opens a chunk starts its bundle at the start byte.
  a_hdr_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (rem_q == '0) |=> out_valid_o && (slot_q == SLOT_START))
    else $error("chunk opened without start byte first");

  // The remaining count never exceeds the clamped chunk size.
  a_rem_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(rem_q) <= LenMax)
    else $error("remaining byte count out of range");

  // After the last byte leaves with no new request, the output goes quiet.
  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && at_last && !in_acc |=> !out_valid_o)
    else $error("bundle not released after its last byte");

  // The slot counter never runs past the last slot of its bundle.
  a_slot_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> slot_q <= slot_last)
    else $error("output slot past end of bundle");

endmodule

`default_nettype wire
